// ===== hw/rtl/hcebp_pkg.sv =====
// Shared package for the code emitter and byte packer.
// Holds request codes, the controller state type and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps

package hcebp_pkg;

  localparam int BYTE_BITS        = 8;
  localparam int PEND_W           = 7;   // at most seven bits wait between items
  localparam int CODE_IN_W        = 32;
  localparam int LEN_IN_W         = 6;
  localparam int SYM_IN_W         = 8;
  localparam int DEF_MAX_CODE_LEN = 32;
  localparam int DEF_SYMBOL_COUNT = 256;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EMIT,
    ST_ERR,
    ST_FLUSH
  } ctl_state_t;

  typedef struct packed {
    logic load_we;       // write table entry from input
    logic rd_en;         // read table entry for input symbol
    logic start;         // merge pending bits with code read
    logic emit_byte;     // send top full byte of accumulator
    logic commit;        // move leftover bits to pending
    logic emit_err;      // send error result
    logic emit_flush;    // send pending bits as final byte
  } ctl_cmd_t;

  typedef struct packed {
    logic hit;           // symbol in range and loaded
    logic pend_nz;       // pending bits exist
    logic ge8;           // accumulator holds a full byte
    logic out_free;      // output register can take a result
  } dp_status_t;

endpackage

// ===== hw/rtl/hcebp_ctrl.sv =====
// Controller state machine for the code emitter and byte packer.
// Depends on hcebp_pkg; drives commands to hcebp_dp, reads its status.
`timescale 1ns / 1ps

module hcebp_ctrl import hcebp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_stall,
  input  dp_status_t sts,
  output ctl_cmd_t   cmd
);

  ctl_state_t state_r, state_nxt;
  logic       accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_ENCODE: state_nxt = sts.hit ? ST_READ : ST_ERR;
            REQ_FLUSH:  state_nxt = sts.pend_nz ? ST_FLUSH : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!sts.ge8) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load_we = accept && (in_req_type == REQ_LOAD);
        cmd.rd_en   = accept && (in_req_type == REQ_ENCODE);
      end
      ST_READ: cmd.start = 1'b1;
      ST_EMIT: begin
        cmd.emit_byte = sts.ge8 && sts.out_free;
        cmd.commit    = !sts.ge8;
      end
      ST_ERR:   cmd.emit_err   = sts.out_free;
      ST_FLUSH: cmd.emit_flush = sts.out_free;
      default: ;
    endcase
  end

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_EMIT))
    else $error("table read not followed by emit");

endmodule

// ===== hw/rtl/hcebp_dp.sv =====
// Datapath: code table, valid marks, bit accumulator, pending bits, output register.
// Depends on hcebp_pkg; controlled by hcebp_ctrl through ctl_cmd_t / dp_status_t.
`timescale 1ns / 1ps

module hcebp_dp import hcebp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [SYM_IN_W-1:0]  in_symbol,
  input  logic [CODE_IN_W-1:0] in_code_word,
  input  logic [LEN_IN_W-1:0]  in_code_length,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [7:0]           out_byte,
  output logic                 out_is_error,
  output logic                 out_last_of_run,
  input  ctl_cmd_t             cmd,
  output dp_status_t           sts
);

  localparam int USABLE = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
  localparam int LEN_W  = $clog2(USABLE + 1);
  localparam int SYM_W  = $clog2(SYMBOL_COUNT);
  localparam int ACC_W  = PEND_W + USABLE;
  localparam int TOT_W  = $clog2(ACC_W + 1);

  logic [LEN_W+USABLE-1:0] mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r;
  logic [LEN_W+USABLE-1:0] rd_q_r;

  logic [ACC_W-1:0]  acc_r;
  logic [TOT_W-1:0]  total_r;
  logic [PEND_W-1:0] pend_bits_r;
  logic [2:0]        pend_cnt_r;

  logic              out_valid_r, out_err_r, out_last_r;
  logic [7:0]        out_byte_r;

  logic [SYM_W-1:0]  sym_idx;
  logic              in_range;
  logic [LEN_W-1:0]  ld_len;
  logic [USABLE:0]   ld_one_sh;
  logic [USABLE:0]   ld_mask_w;
  logic [USABLE-1:0] ld_code;
  logic [LEN_W-1:0]  rd_len;
  logic [USABLE-1:0] rd_code;
  logic [TOT_W-1:0]  tot_m8;
  logic [7:0]        top_byte;
  logic [PEND_W:0]   pend_one_sh;
  logic [PEND_W-1:0] pend_mask;

  assign sym_idx  = in_symbol[SYM_W-1:0];
  assign in_range = ({1'b0, in_symbol} < (SYM_IN_W + 1)'(SYMBOL_COUNT));

  // clamp length, drop code bits above it
  assign ld_len    = (in_code_length > LEN_IN_W'(USABLE)) ? LEN_W'(USABLE)
                                                          : in_code_length[LEN_W-1:0];
  assign ld_one_sh = (USABLE + 1)'(1) << ld_len;
  assign ld_mask_w = ld_one_sh - (USABLE + 1)'(1);
  assign ld_code   = in_code_word[USABLE-1:0] & ld_mask_w[USABLE-1:0];

  assign rd_len  = rd_q_r[LEN_W+USABLE-1:USABLE];
  assign rd_code = rd_q_r[USABLE-1:0];

  assign tot_m8   = total_r - TOT_W'(BYTE_BITS);
  assign top_byte = 8'(acc_r >> tot_m8);

  assign pend_one_sh = (PEND_W + 1)'(1) << total_r[2:0];
  assign pend_mask   = pend_one_sh[PEND_W-1:0] - PEND_W'(1);

  always_comb begin
    sts          = '0;
    sts.hit      = in_range && valid_r[sym_idx];
    sts.pend_nz  = (pend_cnt_r != 3'd0);
    sts.ge8      = (total_r >= TOT_W'(BYTE_BITS));
    sts.out_free = !out_valid_r || !out_stall;
  end

  // table write
  always_ff @(posedge clk) begin
    if (cmd.load_we && in_range) begin
      mem[sym_idx] <= {ld_len, ld_code};
    end
  end

  // table read, registered
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_q_r <= mem[sym_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.load_we && in_range) begin
      valid_r[sym_idx] <= 1'b1;
    end
  end

  // accumulator
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r   <= (ACC_W'(pend_bits_r) << rd_len) | ACC_W'(rd_code);
      total_r <= TOT_W'(pend_cnt_r) + TOT_W'(rd_len);
    end else if (cmd.emit_byte) begin
      total_r <= tot_m8;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (cmd.commit) begin
      pend_bits_r <= acc_r[PEND_W-1:0] & pend_mask;
      pend_cnt_r  <= total_r[2:0];
    end else if (cmd.emit_flush) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_err || cmd.emit_flush) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      out_byte_r <= top_byte;
      out_err_r  <= 1'b0;
      out_last_r <= (tot_m8 < TOT_W'(BYTE_BITS));
    end else if (cmd.emit_err) begin
      out_byte_r <= '0;
      out_err_r  <= 1'b1;
      out_last_r <= 1'b1;
    end else if (cmd.emit_flush) begin
      out_byte_r <= {1'b0, pend_bits_r};
      out_err_r  <= 1'b0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_error    = out_err_r;
  assign out_last_of_run = out_last_r;

  a_pend_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_cnt_r == 3'd0) |-> (pend_bits_r == '0))
    else $error("stale pending bits with zero count");

  a_byte_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_byte |-> (total_r >= TOT_W'(BYTE_BITS)))
    else $error("byte sent from a partial accumulator");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_byte_r == 8'd0 && out_last_r))
    else $error("error result malformed");

endmodule

// ===== hw/rtl/huffman_code_emit_byte_pack.sv =====
// Top level of the code emitter and byte packer.
// Depends on hcebp_pkg, hcebp_ctrl and hcebp_dp.
`timescale 1ns / 1ps

// Packs variable-length code words into bytes. A load request (req_type 0)
// writes a symbol's code word and length into the code table; lengths above
// min(MAX_CODE_LEN, 32) are clamped and code bits above the length dropped.
// An encode request (1) appends the symbol's code, first bit first, to the
// pending bit stream and sends every full byte, earliest bit in the MSB. An
// unloaded or out-of-range symbol gives one result with out_is_error set and
// out_byte zero. A flush request (2) sends leftover bits right-aligned as a
// final byte. out_last_of_run marks the last result of each request; requests
// that produce nothing (loads, encodes that complete no byte, empty flushes,
// code 3) send no result. Timing: one item at a time. An encode steps through
// a table read, a merge, one byte per cycle through the single output register
// while that register is free, then a closing step; an error or a flush waits
// until the output register is free. The output register lets a new item be
// taken while the last result still waits. Valid marks of the table clear at
// reset; no clearing pass is needed and the block is ready the cycle after reset.
module huffman_code_emit_byte_pack import hcebp_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_req_type,
  input  logic [SYM_IN_W-1:0]  in_symbol,
  input  logic [CODE_IN_W-1:0] in_code_word,
  input  logic [LEN_IN_W-1:0]  in_code_length,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_is_error,
  output logic                 out_last_of_run
);

  ctl_cmd_t   cmd;
  dp_status_t sts;

  hcebp_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  hcebp_dp #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ===== bench/huffman_code_emit_byte_pack_test.sv =====
// Testbench for huffman_code_emit_byte_pack: directed and random load, encode and flush traffic,
// checked against a predictor of the code table and the byte packer.
// Depends on hcebp_pkg and the huffman_code_emit_byte_pack RTL.
`timescale 1ns / 1ps

module huffman_code_emit_byte_pack_test;
  import hcebp_pkg::*;

  // Request code 3 is not a valid request; the block must ignore it.
  localparam logic [1:0] REQ_NONE = 2'd3;

  // Usable code length: MAX_CODE_LEN capped at the 32-bit code word.
  localparam int CODE_LIMIT = (DEF_MAX_CODE_LEN < CODE_IN_W) ? DEF_MAX_CODE_LEN : CODE_IN_W;

  // One packed byte as it should leave the block.
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       last;
  } coded_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_req_type = REQ_LOAD;
  logic [SYM_IN_W-1:0]  in_symbol = '0;
  logic [CODE_IN_W-1:0] in_code_word = '0;
  logic [LEN_IN_W-1:0]  in_code_length = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           out_byte;
  logic                 out_is_error;
  logic                 out_last_of_run;

  huffman_code_emit_byte_pack uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_req_type     (in_req_type),
    .in_symbol       (in_symbol),
    .in_code_word    (in_code_word),
    .in_code_length  (in_code_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_is_error    (out_is_error),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  // Predictor state: our own copy of the code table and the pending bits.
  logic [LEN_IN_W-1:0]  tbl_len    [DEF_SYMBOL_COUNT];
  logic [CODE_IN_W-1:0] tbl_word   [DEF_SYMBOL_COUNT];
  logic                 tbl_loaded [DEF_SYMBOL_COUNT];
  logic [PEND_W-1:0]    pend_bits  = '0;
  int unsigned          pend_count = 0;

  coded_byte_t   expected_bytes[$];   // bytes still owed by the block, oldest first
  logic [7:0]    loaded_syms[$];      // symbols that have a code, for well-formed encodes
  int            fail_count = 0;

  // Idle rates in percent, and a long receiver hold-off counted down below.
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   recv_hold_left = 0;

  initial begin
    for (int i = 0; i < DEF_SYMBOL_COUNT; i++) begin
      tbl_len[i]    = '0;
      tbl_word[i]   = '0;
      tbl_loaded[i] = 1'b0;
    end
  end

  function automatic logic [63:0] bits_below(input int unsigned n);
    return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  // Works out the bytes one accepted transfer must produce and queues them.
  task automatic predict_item(input logic [1:0] req, input logic [7:0] sym,
                              input logic [31:0] word, input logic [5:0] len);
    int unsigned eff_len;
    int unsigned total;
    int unsigned nbytes;
    logic [63:0] acc;
    coded_byte_t res;
    eff_len = (len > CODE_LIMIT) ? CODE_LIMIT : len;
    case (req)
      REQ_LOAD: begin
        // Length clamps, code bits above the length are dropped.
        tbl_len[sym]    = LEN_IN_W'(eff_len);
        tbl_word[sym]   = word & CODE_IN_W'(bits_below(eff_len));
        tbl_loaded[sym] = 1'b1;
        loaded_syms.push_back(sym);
      end
      REQ_ENCODE: begin
        if (!tbl_loaded[sym]) begin
          // Unloaded symbol: one error result, pending bits untouched.
          res.data = 8'h00;
          res.err  = 1'b1;
          res.last = 1'b1;
          expected_bytes.push_back(res);
        end else begin
          eff_len = tbl_len[sym];
          acc     = (64'(pend_bits) << eff_len) | 64'(tbl_word[sym]);
          total   = pend_count + eff_len;
          nbytes  = total / 8;
          // Earliest bit goes to the MSB; a zero-length code yields nothing.
          for (int k = 0; k < nbytes; k++) begin
            res.data = 8'(acc >> (total - 8 * (k + 1)));
            res.err  = 1'b0;
            res.last = (k == nbytes - 1);
            expected_bytes.push_back(res);
          end
          pend_count = total % 8;
          pend_bits  = PEND_W'(acc & bits_below(pend_count));
        end
      end
      REQ_FLUSH: begin
        // Leftover bits leave right-aligned; an empty flush is silent.
        if (pend_count != 0) begin
          res.data = 8'(pend_bits);
          res.err  = 1'b0;
          res.last = 1'b1;
          expected_bytes.push_back(res);
        end
        pend_bits  = '0;
        pend_count = 0;
      end
      default: ;
    endcase
  endtask

  // Offers one item, holds it until the transfer, then predicts. Valid stays
  // high on return so back-to-back items need no second assignment per step.
  task automatic send_item(input logic [1:0] req, input logic [7:0] sym,
                           input logic [31:0] word, input logic [5:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_symbol      <= sym;
    in_code_word   <= word;
    in_code_length <= len;
    do @(posedge clk); while (in_stall);
    predict_item(req, sym, word, len);
  endtask

  // Drops valid and waits until every owed byte has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_loaded();
    return loaded_syms[$urandom_range(loaded_syms.size() - 1)];
  endfunction

  // Receiver side: random stall at the current rate, or a long hold-off.
  always @(posedge clk) begin
    if (recv_hold_left > 0) begin
      out_stall <= 1'b1;
      recv_hold_left <= recv_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result checker: every transfer on the output is matched to the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    coded_byte_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: out_byte %02h out_is_error %0b out_last_of_run %0b",
               out_byte, out_is_error, out_last_of_run);
        fail_count++;
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
          fail_count++;
        end
        if (out_is_error !== want.err) begin
          $error("out_is_error: expected %0b, actual %0b", want.err, out_is_error);
          fail_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run: expected %0b, actual %0b", want.last, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // Hand-picked items: empty flush, ignored request, unloaded symbol,
  // zero-length code, clamped lengths, masked code bits, 39-bit merges.
  task automatic test_directed_cases();
    send_item(REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
    send_item(REQ_NONE,   8'd9,   32'hDEAD_BEEF, 6'd12);
    send_item(REQ_ENCODE, 8'd0,   32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd0,   32'hFFFF_FFFF, 6'd0);
    send_item(REQ_ENCODE, 8'd0,   32'hFFFF_FFFF, 6'd63);
    send_item(REQ_LOAD,   8'd255, 32'hFFFF_FFFF, 6'd32);
    send_item(REQ_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd1,   32'h0000_0001, 6'd1);
    send_item(REQ_ENCODE, 8'd1,   32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd128, 32'h1234_5678, 6'd63);
    send_item(REQ_ENCODE, 8'd128, 32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd2,   32'hFFFF_FFD5, 6'd7);
    send_item(REQ_ENCODE, 8'd2,   32'h0000_0000, 6'd0);
    send_item(REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd3,   32'h0000_0005, 6'd3);
    send_item(REQ_ENCODE, 8'd3,   32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
    send_item(REQ_FLUSH,  8'd0,   32'h0000_0000, 6'd0);
    send_item(REQ_LOAD,   8'd4,   32'h0000_007F, 6'd7);
    send_item(REQ_ENCODE, 8'd4,   32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'd255, 32'h0000_0000, 6'd0);
    send_item(REQ_FLUSH,  8'd255, 32'hFFFF_FFFF, 6'd63);
    send_item(REQ_LOAD,   8'd5,   32'h0000_0000, 6'd33);
    send_item(REQ_ENCODE, 8'd5,   32'h0000_0000, 6'd0);
    send_item(REQ_ENCODE, 8'd77,  32'hFFFF_FFFF, 6'd63);
    send_item(REQ_NONE,   8'd255, 32'hFFFF_FFFF, 6'd63);
  endtask

  // Mostly loads and encodes of loaded symbols with random codes; flushes,
  // unloaded symbols and ignored requests mixed in.
  task automatic test_random_stream(input int count);
    int unsigned roll;
    int unsigned pick;
    logic [5:0]  len;
    logic [7:0]  sym;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 15 || loaded_syms.size() == 0) begin
        pick = $urandom_range(99);
        if (pick < 5)       len = 6'd0;
        else if (pick < 15) len = 6'($urandom_range(63, 33));
        else if (pick < 30) len = 6'($urandom_range(32, 17));
        else                len = 6'($urandom_range(16, 1));
        send_item(REQ_LOAD, 8'($urandom_range(255)), $urandom, len);
      end else if (roll < 82) begin
        sym = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : pick_loaded();
        send_item(REQ_ENCODE, sym, $urandom, 6'($urandom));
      end else if (roll < 96) begin
        send_item(REQ_FLUSH, 8'($urandom), $urandom, 6'($urandom));
      end else begin
        send_item(REQ_NONE, 8'($urandom), $urandom, 6'($urandom));
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // encodes of loaded symbols, so the output register fills and the input stalls.
  task automatic test_receiver_holdoff();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(REQ_LOAD, 8'd200, $urandom, 6'd29);
    recv_hold_left = 120;
    repeat (20) send_item(REQ_ENCODE, pick_loaded(), $urandom, 6'($urandom));
    send_item(REQ_FLUSH, 8'd0, 32'h0, 6'd0);
  endtask

  // Sender goes quiet until every byte is back, then resumes.
  task automatic test_sender_pause();
    wait_for_drain();
    repeat (10) @(posedge clk);
    send_idle_pct  = 14;
    recv_stall_pct = 14;
    test_random_stream(12);
    send_item(REQ_FLUSH, 8'd0, 32'h0, 6'd0);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: sender idles rarely, receiver stalls often.
    send_idle_pct  = 14;
    recv_stall_pct = 64;
    test_directed_cases();
    test_random_stream(140);

    // Phase 2: the other way round.
    send_idle_pct  = 64;
    recv_stall_pct = 14;
    test_random_stream(140);

    // Phase 3: full rate on both sides.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_stream(140);

    test_receiver_holdoff();
    test_sender_pause();

    // Drain with a bound, then let the block settle.
    in_valid <= 1'b0;
    for (int i = 0; i < 5000 && expected_bytes.size() != 0; i++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $error("%0d expected results never arrived", expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** huffman_code_emit_byte_pack: PASSED **");
    end else begin
      $display("** huffman_code_emit_byte_pack: FAILED **");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run.
  initial begin
    #3_000_000;
    $display("** huffman_code_emit_byte_pack: FAILED **");
    $finish;
  end

endmodule
